// ===== rtl/e2p_pkg.sv =====
`default_nettype none

package e2p_pkg;

   // field and register widths
   localparam int unsigned PIX_W = 13;
   localparam int unsigned DIM_W = 14;
   localparam int unsigned ROT_W = 48;
   localparam int unsigned OUT_W = 20;
   localparam int unsigned CSR_IDX_W = 3;

   // cordic datapath
   localparam int unsigned STEPS = 20;
   localparam int unsigned CW = 48;
   localparam int unsigned AW = 34;
   localparam int unsigned CORDIC_LAT = STEPS + 1;
   localparam int unsigned LAT = 8 + 2 * CORDIC_LAT;

   localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
   localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;
   localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
   localparam logic signed [AW-1:0] HALF_TURN = 34'sh0_8000_0000;

   // arctangent of 2^-i, full turn is 2^32
   localparam logic [30:0] ATAN_TAB [32] = '{
      31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
      31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
      31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
      31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
      31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
   };

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_WIDTH   = 3'd0,
      REG_IN_HEIGHT  = 3'd1,
      REG_OUT_WIDTH  = 3'd2,
      REG_OUT_HEIGHT = 3'd3,
      REG_ROT_ROW_X  = 3'd4,
      REG_ROT_ROW_Y  = 3'd5,
      REG_ROT_ROW_Z  = 3'd6
   } csr_index_type;

   // saturate a coordinate to the output range
   function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [21:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 22'sd524287) begin
         r = 20'sd524287;
      end else if (v < -22'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/e2p_if.sv =====
`default_nettype none

interface e2p_req_if;
   logic                          valid;
   logic                          ready;
   logic [e2p_pkg::PIX_W-1:0]     pix_col;
   logic [e2p_pkg::PIX_W-1:0]     pix_row;
   modport source (output valid, output pix_col, output pix_row, input ready);
   modport sink (input valid, input pix_col, input pix_row, output ready);
endinterface

interface e2p_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [e2p_pkg::OUT_W-1:0]  src_x;
   logic signed [e2p_pkg::OUT_W-1:0]  src_y;
   modport source (output valid, output src_x, output src_y, input ready);
   modport sink (input valid, input src_x, input src_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/e2p_cordic.sv =====
`default_nettype none

module e2p_cordic (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic signed [e2p_pkg::CW-1:0]    xv,
   input  wire logic signed [e2p_pkg::CW-1:0]    yv,
   output logic signed [e2p_pkg::AW-1:0]         ang,
   output logic signed [e2p_pkg::CW-1:0]         mag
);

   logic signed [e2p_pkg::CW-1:0] x_ff [e2p_pkg::STEPS+1];
   logic signed [e2p_pkg::CW-1:0] y_ff [e2p_pkg::STEPS+1];
   logic signed [e2p_pkg::AW-1:0] a_ff [e2p_pkg::STEPS+1];
   logic                          zero_ff [e2p_pkg::STEPS+1];

   // quarter-turn pre-rotation into the right half plane
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (xv == '0) && (yv == '0);
         if (xv < 0) begin
            if (yv >= 0) begin
               x_ff[0] <= yv;
               y_ff[0] <= -xv;
               a_ff[0] <= e2p_pkg::QUARTER_TURN;
            end else begin
               x_ff[0] <= -yv;
               y_ff[0] <= xv;
               a_ff[0] <= -e2p_pkg::QUARTER_TURN;
            end
         end else begin
            x_ff[0] <= xv;
            y_ff[0] <= yv;
            a_ff[0] <= '0;
         end
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < e2p_pkg::STEPS; i++) begin : g_step
      logic signed [e2p_pkg::CW-1:0] dx;
      logic signed [e2p_pkg::CW-1:0] dy;
      logic signed [e2p_pkg::AW-1:0] da;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign da = $signed({3'b000, e2p_pkg::ATAN_TAB[i]});
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][e2p_pkg::CW-1]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               a_ff[i+1] <= a_ff[i] + da;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               a_ff[i+1] <= a_ff[i] - da;
            end
         end
      end
   end

   // zero vector gives angle and length zero
   assign ang = zero_ff[e2p_pkg::STEPS] ? '0 : a_ff[e2p_pkg::STEPS];
   assign mag = zero_ff[e2p_pkg::STEPS] ? '0 : x_ff[e2p_pkg::STEPS];

endmodule

`default_nettype wire

// ===== rtl/equirect_to_perspective_map.sv =====
// Maps perspective output pixels to sample positions in an equirectangular image.
// req channel: one transaction carries pix_col and pix_row of an output pixel.
// rsp channel: one transaction carries src_x and src_y, signed, in 1/32 pixel.
// csr port: csr_we writes csr_wdata into the register selected by csr_index
// (in_width, in_height, out_width, out_height, rot_row_x/y/z); change these only
// while no transaction is in flight. Unknown indexes are ignored.
// From req to rsp the data passes three stages that form the rotated vector,
// the two 20-step vectoring cordic pipelines, the gain correction (partial
// products, then their sum) and the final scaling (phi clamp, scaling, rounding).
// Throughput is one transaction per cycle while rsp is not stalled; every
// stage is a register stage. When rsp is stalled with a result waiting, the
// whole pipeline holds and req.ready drops, even with bubbles in the pipeline.
// Synchronous reset empties the pipeline and loads the default registers
// (4096x2048 source, 1024x1024 view, identity rotation).
`default_nettype none

module equirect_to_perspective_map (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   e2p_req_if.sink                                    req,
   e2p_rsp_if.source                                  rsp,
   input  wire logic                                  csr_we,
   input  wire logic [e2p_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [e2p_pkg::ROT_W-1:0]             csr_wdata
);

   localparam int unsigned LC = e2p_pkg::CORDIC_LAT;

   logic [e2p_pkg::DIM_W-1:0] in_width_ff, in_height_ff, out_width_ff, out_height_ff;
   logic [e2p_pkg::ROT_W-1:0] rot_ff [3];
   logic                      vld_ff [e2p_pkg::LAT];
   logic                      en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= 14'd4096;
         in_height_ff  <= 14'd2048;
         out_width_ff  <= 14'd1024;
         out_height_ff <= 14'd1024;
         rot_ff[0]     <= 48'h4000_0000_0000;
         rot_ff[1]     <= 48'h0000_4000_0000;
         rot_ff[2]     <= 48'h0000_0000_4000;
      end else if (csr_we) begin
         case (e2p_pkg::csr_index_type'(csr_index))
            e2p_pkg::REG_IN_WIDTH:   in_width_ff   <= csr_wdata[e2p_pkg::DIM_W-1:0];
            e2p_pkg::REG_IN_HEIGHT:  in_height_ff  <= csr_wdata[e2p_pkg::DIM_W-1:0];
            e2p_pkg::REG_OUT_WIDTH:  out_width_ff  <= csr_wdata[e2p_pkg::DIM_W-1:0];
            e2p_pkg::REG_OUT_HEIGHT: out_height_ff <= csr_wdata[e2p_pkg::DIM_W-1:0];
            e2p_pkg::REG_ROT_ROW_X:  rot_ff[0]     <= csr_wdata;
            e2p_pkg::REG_ROT_ROW_Y:  rot_ff[1]     <= csr_wdata;
            e2p_pkg::REG_ROT_ROW_Z:  rot_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances unless a finished result is stalled
   assign en        = !vld_ff[e2p_pkg::LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < e2p_pkg::LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int k = 1; k < e2p_pkg::LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: centered camera vector, focal length
   logic signed [13:0] col_off, row_off;
   logic [44:0]        c_prod;
   logic signed [21:0] vec_ff [3];

   assign col_off = $signed({1'b0, req.pix_col}) - $signed({1'b0, out_width_ff[13:1]});
   assign row_off = $signed({1'b0, req.pix_row}) - $signed({1'b0, out_height_ff[13:1]});
   assign c_prod  = {31'd0, in_height_ff} * {14'd0, e2p_pkg::INV_PI_Q32} + 45'h80_0000;

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff[0] <= {col_off, 8'd0};
         vec_ff[1] <= {row_off, 8'd0};
         vec_ff[2] <= $signed({1'b0, c_prod[44:24]});
      end
   end

   // stage 2: matrix entry products
   logic signed [37:0] prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= $signed(rot_ff[r][47-16*k -: 16]) * vec_ff[k];
            end
         end
      end
   end

   // stage 3: row sums give the rotated vector
   logic signed [39:0] rv_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            rv_ff[r] <= 40'(prod_ff[r][0]) + 40'(prod_ff[r][1]) + 40'(prod_ff[r][2]);
         end
      end
   end

   // horizontal angle and horizontal length
   logic signed [e2p_pkg::AW-1:0] ang1, ang2;
   logic signed [e2p_pkg::CW-1:0] mag1, mag2;

   e2p_cordic u_cordic_theta (
      .clock (clock),
      .en    (en),
      .xv    ({{8{rv_ff[2][39]}}, rv_ff[2]}),
      .yv    ({{8{rv_ff[0][39]}}, rv_ff[0]}),
      .ang   (ang1),
      .mag   (mag1)
   );

   // y component waits for the second cordic
   logic signed [39:0] y_dly_ff [LC+2];

   always_ff @(posedge clock) begin
      if (en) begin
         y_dly_ff[0] <= rv_ff[1];
         for (int k = 1; k < LC + 2; k++) begin
            y_dly_ff[k] <= y_dly_ff[k-1];
         end
      end
   end

   // gain correction partial products, theta clamp and offset
   logic signed [e2p_pkg::AW-1:0] t_wide;
   logic [32:0]                   t_in;
   logic [43:0]                   lo_ff;
   logic signed [44:0]            hi_ff;
   logic [32:0]                   t_dly_ff [LC+3];

   assign t_wide = ang1 + e2p_pkg::HALF_TURN;

   always_comb begin
      if (t_wide < 0) begin
         t_in = '0;
      end else if (t_wide > 34'sh1_0000_0000) begin
         t_in = 33'h1_0000_0000;
      end else begin
         t_in = t_wide[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= {20'd0, mag1[23:0]} * {24'd0, e2p_pkg::INV_GAIN_Q20};
         hi_ff <= $signed(mag1[47:24]) * $signed({1'b0, e2p_pkg::INV_GAIN_Q20});
         t_dly_ff[0] <= t_in;
         for (int k = 1; k < LC + 3; k++) begin
            t_dly_ff[k] <= t_dly_ff[k-1];
         end
      end
   end

   // combine partial products into the corrected length
   logic signed [49:0]            r_sum;
   logic signed [e2p_pkg::CW-1:0] r_ff;

   assign r_sum = (50'(hi_ff) <<< 4) + $signed({26'd0, lo_ff[43:20]});

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_sum[e2p_pkg::CW-1:0];
      end
   end

   // polar angle
   e2p_cordic u_cordic_phi (
      .clock (clock),
      .en    (en),
      .xv    ({{8{y_dly_ff[LC+1][39]}}, y_dly_ff[LC+1]}),
      .yv    (r_ff),
      .ang   (ang2),
      .mag   (mag2)
   );

   // phi clamp and offset
   logic [31:0] p_in, p_ff;

   always_comb begin
      if (ang2 < 0) begin
         p_in = 32'h8000_0000;
      end else if (ang2 > e2p_pkg::HALF_TURN) begin
         p_in = '0;
      end else begin
         p_in = 32'h8000_0000 - ang2[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   // scale angles by the source size
   logic [46:0] px_ff;
   logic [45:0] py_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= {14'd0, t_dly_ff[LC+2]} * {33'd0, in_width_ff};
         py_ff <= {14'd0, p_ff} * {32'd0, in_height_ff};
      end
   end

   // half-pixel shift, round and saturate into the output register
   logic signed [54:0] numx;
   logic signed [53:0] numy;
   logic signed [e2p_pkg::OUT_W-1:0] src_x_ff, src_y_ff;

   assign numx = $signed({2'b00, px_ff, 6'd0}) + 55'sh1_0000_0000 - 55'sh20_0000_0000;
   assign numy = $signed({2'b00, py_ff, 6'd0}) + 54'sh8000_0000 - 54'sh10_0000_0000;

   always_ff @(posedge clock) begin
      if (en) begin
         src_x_ff <= e2p_pkg::sat_coord(numx[54:33]);
         src_y_ff <= e2p_pkg::sat_coord(numy[53:32]);
      end
   end

   assign rsp.valid = vld_ff[e2p_pkg::LAT-1];
   assign rsp.src_x = src_x_ff;
   assign rsp.src_y = src_y_ff;

`ifndef SYNTHESIS
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("transaction accepted while result stalled");

   a_theta_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LC+3] |-> (t_dly_ff[0] <= 33'h1_0000_0000))
      else $error("theta offset out of range");

   a_phi_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2*LC+5] |-> (p_ff <= 32'h8000_0000))
      else $error("phi offset out of range");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(src_x_ff) && $stable(src_y_ff))
      else $error("output register changed during stall");
`endif

endmodule

`default_nettype wire
